/* design/avt_pkg.sv */
// Shared types and constants for the affine vertex transform.
// Holds the matrix row layout, pipeline control struct and register map.
// No dependencies.
`default_nettype none

package avt_pkg;

  // Register file geometry: six 64-bit registers at 8-byte spacing.
  localparam int unsigned NUM_REGS  = 6;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned ADDR_W    = 6;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_ROW_X_AB    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW_X_C_OFF = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROW_Y_AB    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROW_Y_C_OFF = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROW_Z_AB    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ROW_Z_C_OFF = 3'd5;

  // Reset gives the identity transform (1.0 in Q16.16 on the diagonal).
  localparam logic [DATA_W-1:0] RST_ROW_X_AB    = 64'h0000_0000_0001_0000;
  localparam logic [DATA_W-1:0] RST_ROW_X_C_OFF = 64'h0000_0000_0000_0000;
  localparam logic [DATA_W-1:0] RST_ROW_Y_AB    = 64'h0001_0000_0000_0000;
  localparam logic [DATA_W-1:0] RST_ROW_Y_C_OFF = 64'h0000_0000_0000_0000;
  localparam logic [DATA_W-1:0] RST_ROW_Z_AB    = 64'h0000_0000_0000_0000;
  localparam logic [DATA_W-1:0] RST_ROW_Z_C_OFF = 64'h0000_0000_0001_0000;

  localparam int unsigned NUM_LANES = 3;

  // One matrix row: coefficients of x, y, z and the translation.
  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] t;
  } avt_row_t;

  // Per-stage load enables driven by the pipeline control in the top level.
  typedef struct packed {
    logic en_mul;
    logic en_sum;
    logic en_sat;
    logic en_out;
  } avt_ctl_t;

endpackage

`default_nettype wire

/* design/avt_regs.sv */
// Configuration register file for the affine vertex transform.
// APB-style write and read of the six 64-bit matrix registers; uses avt_pkg.
`default_nettype none

module avt_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [avt_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [avt_pkg::DATA_W-1:0]   pwdata,
  output logic      [avt_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  output avt_pkg::avt_row_t                 rows_o [avt_pkg::NUM_LANES]
);

  logic [avt_pkg::DATA_W-1:0]    regs_q [avt_pkg::NUM_REGS];
  logic [avt_pkg::REG_IDX_W-1:0] idx;
  logic                          idx_ok;
  logic                          wr_en;

  assign idx    = paddr[avt_pkg::ADDR_W-1:3];
  assign idx_ok = idx < avt_pkg::REG_IDX_W'(avt_pkg::NUM_REGS);
  assign wr_en  = psel && penable && pwrite && idx_ok;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[avt_pkg::REG_ROW_X_AB]    <= avt_pkg::RST_ROW_X_AB;
      regs_q[avt_pkg::REG_ROW_X_C_OFF] <= avt_pkg::RST_ROW_X_C_OFF;
      regs_q[avt_pkg::REG_ROW_Y_AB]    <= avt_pkg::RST_ROW_Y_AB;
      regs_q[avt_pkg::REG_ROW_Y_C_OFF] <= avt_pkg::RST_ROW_Y_C_OFF;
      regs_q[avt_pkg::REG_ROW_Z_AB]    <= avt_pkg::RST_ROW_Z_AB;
      regs_q[avt_pkg::REG_ROW_Z_C_OFF] <= avt_pkg::RST_ROW_Z_C_OFF;
    end else if (wr_en) begin
      regs_q[idx] <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (idx_ok) begin
      prdata = regs_q[idx];
    end
  end

  // Each row spans two registers: {b, a} then {t, c}.
  always_comb begin
    for (int r = 0; r < avt_pkg::NUM_LANES; r++) begin
      rows_o[r].a = regs_q[2*r][31:0];
      rows_o[r].b = regs_q[2*r][63:32];
      rows_o[r].c = regs_q[2*r+1][31:0];
      rows_o[r].t = regs_q[2*r+1][63:32];
    end
  end

endmodule

`default_nettype wire

/* design/avt_lane.sv */
// One row lane of the affine vertex transform: multiply, sum, shift, saturate.
// Three pipeline stages of payload registers; uses avt_pkg.
`default_nettype none

module avt_lane #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire avt_pkg::avt_ctl_t  ctl_i,
  input  wire avt_pkg::avt_row_t  row_i,
  input  wire logic               with_t_i,
  input  wire logic signed [31:0] x_i,
  input  wire logic signed [31:0] y_i,
  input  wire logic signed [31:0] z_i,
  output logic signed [31:0]      res_o,
  output logic                    ovf_o
);

  localparam int unsigned SW = 66;  // three 64-bit products summed
  localparam int unsigned RW = 67;  // plus the translation

  localparam logic signed [RW-1:0] MAXV =
    {{(RW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [RW-1:0] MINV =
    {{(RW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  logic signed [63:0] px_q, py_q, pz_q;
  logic               wt1_q, wt2_q;
  logic signed [SW-1:0] sum_d, sum_q;
  logic signed [SW-1:0] sum_sh;
  logic signed [RW-1:0] tot;
  logic signed [RW-1:0] sat;
  logic                 ovf_d;
  logic signed [31:0]   res_q;
  logic                 ovf_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_mul) begin
      px_q  <= row_i.a * x_i;
      py_q  <= row_i.b * y_i;
      pz_q  <= row_i.c * z_i;
      wt1_q <= with_t_i;
    end
  end

  assign sum_d = {{2{px_q[63]}}, px_q} + {{2{py_q[63]}}, py_q} + {{2{pz_q[63]}}, pz_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_sum) begin
      sum_q <= sum_d;
      wt2_q <= wt1_q;
    end
  end

  // The arithmetic shift floors the exact sum; the translation is whole.
  assign sum_sh = sum_q >>> FRAC_BITS;

  always_comb begin
    tot = {sum_sh[SW-1], sum_sh};
    if (wt2_q) begin
      tot = tot + {{(RW-32){row_i.t[31]}}, row_i.t};
    end
    sat   = tot;
    ovf_d = 1'b0;
    if (tot > MAXV) begin
      sat   = MAXV;
      ovf_d = 1'b1;
    end else if (tot < MINV) begin
      sat   = MINV;
      ovf_d = 1'b1;
    end
  end

  // The saturated value lies in the coordinate range, so its low 32 bits
  // are already sign-extended.
  always_ff @(posedge clk_i) begin
    if (ctl_i.en_sat) begin
      res_q <= sat[31:0];
      ovf_q <= ovf_d;
    end
  end

  assign res_o = res_q;
  assign ovf_o = ovf_q;

endmodule

`default_nettype wire

/* design/avt_merge.sv */
// Output stage of the affine vertex transform: gathers the three lane results
// and ORs their saturation flags into one overflow flag; uses avt_pkg.
`default_nettype none

module avt_merge (
  input  wire logic               clk_i,
  input  wire avt_pkg::avt_ctl_t  ctl_i,
  input  wire logic signed [31:0] res_i [avt_pkg::NUM_LANES],
  input  wire logic               ovf_i [avt_pkg::NUM_LANES],
  output logic signed [31:0]      out_x_o,
  output logic signed [31:0]      out_y_o,
  output logic signed [31:0]      out_z_o,
  output logic                    overflow_o
);

  logic signed [31:0] x_q, y_q, z_q;
  logic               ovf_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_out) begin
      x_q   <= res_i[0];
      y_q   <= res_i[1];
      z_q   <= res_i[2];
      ovf_q <= ovf_i[0] | ovf_i[1] | ovf_i[2];
    end
  end

  assign out_x_o    = x_q;
  assign out_y_o    = y_q;
  assign out_z_o    = z_q;
  assign overflow_o = ovf_q;

endmodule

`default_nettype wire

/* design/affine_vertex_transform.sv */
// Affine vertex transform: applies the upper 3x4 part of a 4x4 matrix to a
// vertex in signed Q16.16. Uses avt_pkg, avt_regs, avt_lane and avt_merge.
//
// Usage: the input channel (in_valid_i / in_stall_o) carries one word per
// vertex: action_i (0 = point, translation added; 1 = direction, none) and
// in_x_i, in_y_i, in_z_i. The output channel (out_valid_o / out_stall_i)
// returns out_x_o, out_y_o, out_z_o and overflow_o, which is high when any
// coordinate saturated. The matrix lives in six 64-bit registers on the APB
// port, at byte address 8*i; write them only while no word is in flight.
// Throughput is one word per cycle while the output does not stall. A word
// passes the multiply, sum, saturate and merge registers in order. Three row
// lanes run side by side, each a multiply stage, a sum stage and a
// shift/saturate stage, and a merge stage registers the result.
// When the receiver stalls, the output word holds; earlier stages keep
// filling any empty slots, so the input stalls only once the pipe is full.
// Reset empties the pipeline and loads the identity matrix.
`default_nettype none

module affine_vertex_transform #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [avt_pkg::ADDR_W-1:0] paddr,
  input  wire logic [avt_pkg::DATA_W-1:0] pwdata,
  output logic      [avt_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       action_i,
  input  wire logic signed [31:0]         in_x_i,
  input  wire logic signed [31:0]         in_y_i,
  input  wire logic signed [31:0]         in_z_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic signed [31:0]              out_x_o,
  output logic signed [31:0]              out_y_o,
  output logic signed [31:0]              out_z_o,
  output logic                            overflow_o
);

  localparam int unsigned XS = 32 - COORD_WIDTH;

  avt_pkg::avt_row_t rows [avt_pkg::NUM_LANES];
  avt_pkg::avt_ctl_t ctl;

  logic v_mul_q, v_sum_q, v_sat_q, v_out_q;
  logic v_mul_d, v_sum_d, v_sat_d, v_out_d;

  logic signed [31:0] x_ext, y_ext, z_ext;
  logic               with_t;
  logic signed [31:0] lane_res [avt_pkg::NUM_LANES];
  logic               lane_ovf [avt_pkg::NUM_LANES];

  avt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rows_o  (rows)
  );

  // A stage loads when it is empty or its contents move on this cycle.
  always_comb begin
    ctl.en_out = !v_out_q || !out_stall_i;
    ctl.en_sat = !v_sat_q || ctl.en_out;
    ctl.en_sum = !v_sum_q || ctl.en_sat;
    ctl.en_mul = !v_mul_q || ctl.en_sum;
  end

  assign in_stall_o = !ctl.en_mul;

  always_comb begin
    v_mul_d = ctl.en_mul ? in_valid_i : v_mul_q;
    v_sum_d = ctl.en_sum ? v_mul_q    : v_sum_q;
    v_sat_d = ctl.en_sat ? v_sum_q    : v_sat_q;
    v_out_d = ctl.en_out ? v_sat_q    : v_out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_mul_q <= 1'b0;
      v_sum_q <= 1'b0;
      v_sat_q <= 1'b0;
      v_out_q <= 1'b0;
    end else begin
      v_mul_q <= v_mul_d;
      v_sum_q <= v_sum_d;
      v_sat_q <= v_sat_d;
      v_out_q <= v_out_d;
    end
  end

  assign out_valid_o = v_out_q;

  // Only the low COORD_WIDTH bits of each coordinate count.
  assign x_ext  = $signed(in_x_i << XS) >>> XS;
  assign y_ext  = $signed(in_y_i << XS) >>> XS;
  assign z_ext  = $signed(in_z_i << XS) >>> XS;
  assign with_t = !action_i;

  for (genvar r = 0; r < avt_pkg::NUM_LANES; r++) begin : g_lane
    avt_lane #(
      .FRAC_BITS   (FRAC_BITS),
      .COORD_WIDTH (COORD_WIDTH)
    ) u_lane (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .row_i    (rows[r]),
      .with_t_i (with_t),
      .x_i      (x_ext),
      .y_i      (y_ext),
      .z_i      (z_ext),
      .res_o    (lane_res[r]),
      .ovf_o    (lane_ovf[r])
    );
  end

  avt_merge u_merge (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .res_i      (lane_res),
    .ovf_i      (lane_ovf),
    .out_x_o    (out_x_o),
    .out_y_o    (out_y_o),
    .out_z_o    (out_z_o),
    .overflow_o (overflow_o)
  );

endmodule

`default_nettype wire

/* tb/avt_result_check.sv */
// Result checker for the affine vertex transform: tracks the matrix through the APB
// port and predicts each transformed vertex. It compares the predictions in order
// with the output channel. Depends on avt_pkg.
`default_nettype none

module avt_result_check #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic                       pready,
  input  wire logic [avt_pkg::ADDR_W-1:0] paddr,
  input  wire logic [avt_pkg::DATA_W-1:0] pwdata,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_stall_i,
  input  wire logic                       action_i,
  input  wire logic signed [31:0]         in_x_i,
  input  wire logic signed [31:0]         in_y_i,
  input  wire logic signed [31:0]         in_z_i,
  input  wire logic                       out_valid_i,
  input  wire logic                       out_stall_i,
  input  wire logic signed [31:0]         out_x_i,
  input  wire logic signed [31:0]         out_y_i,
  input  wire logic signed [31:0]         out_z_i,
  input  wire logic                       overflow_i,
  output int unsigned                     errors_o,
  output int unsigned                     pending_o,
  output int unsigned                     results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               overflow;
  } vertex_t;

  localparam logic signed [95:0] SAT_MAX = (96'sd1 <<< (COORD_WIDTH - 1)) - 96'sd1;
  localparam logic signed [95:0] SAT_MIN = -SAT_MAX - 96'sd1;

  logic [avt_pkg::DATA_W-1:0] matrix_q [avt_pkg::NUM_REGS];
  vertex_t                    expected_vertices [$];

  // Only the low COORD_WIDTH bits of a coordinate count, sign-extended.
  function automatic logic signed [95:0] narrow_coord(logic signed [31:0] v);
    logic signed [31:0] s;
    s = (v <<< (32 - COORD_WIDTH)) >>> (32 - COORD_WIDTH);
    return 96'(s);
  endfunction

  function automatic vertex_t transform_vertex(logic is_dir, logic signed [31:0] x,
                                               logic signed [31:0] y, logic signed [31:0] z);
    vertex_t                    res;
    logic [avt_pkg::DATA_W-1:0] ab;
    logic [avt_pkg::DATA_W-1:0] c_off;
    logic signed [95:0]         wx, wy, wz;
    logic signed [95:0]         ka, kb, kc, kt;
    logic signed [95:0]         acc;
    logic signed [31:0]         lane [avt_pkg::NUM_LANES];
    wx = narrow_coord(x);
    wy = narrow_coord(y);
    wz = narrow_coord(z);
    res.overflow = 1'b0;
    for (int r = 0; r < avt_pkg::NUM_LANES; r++) begin
      ab    = matrix_q[2*r];
      c_off = matrix_q[2*r+1];
      ka    = 96'($signed(ab[31:0]));
      kb    = 96'($signed(ab[63:32]));
      kc    = 96'($signed(c_off[31:0]));
      kt    = 96'($signed(c_off[63:32]));
      // The sum is exact at 96 bits, so one arithmetic shift gives the floor.
      acc = ka * wx + kb * wy + kc * wz;
      if (!is_dir) begin
        acc = acc + (kt <<< FRAC_BITS);
      end
      acc = acc >>> FRAC_BITS;
      if (acc > SAT_MAX) begin
        acc = SAT_MAX;
        res.overflow = 1'b1;
      end else if (acc < SAT_MIN) begin
        acc = SAT_MIN;
        res.overflow = 1'b1;
      end
      lane[r] = acc[31:0];
    end
    res.x = lane[0];
    res.y = lane[1];
    res.z = lane[2];
    return res;
  endfunction

  function automatic int unsigned check_field(string name, logic signed [31:0] want,
                                              logic signed [31:0] seen);
    if (want !== seen) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, seen);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t     want_v;
    vertex_t     seen_v;
    int unsigned bad;
    if (!rst_ni) begin
      matrix_q[avt_pkg::REG_ROW_X_AB]    <= avt_pkg::RST_ROW_X_AB;
      matrix_q[avt_pkg::REG_ROW_X_C_OFF] <= avt_pkg::RST_ROW_X_C_OFF;
      matrix_q[avt_pkg::REG_ROW_Y_AB]    <= avt_pkg::RST_ROW_Y_AB;
      matrix_q[avt_pkg::REG_ROW_Y_C_OFF] <= avt_pkg::RST_ROW_Y_C_OFF;
      matrix_q[avt_pkg::REG_ROW_Z_AB]    <= avt_pkg::RST_ROW_Z_AB;
      matrix_q[avt_pkg::REG_ROW_Z_C_OFF] <= avt_pkg::RST_ROW_Z_C_OFF;
      expected_vertices.delete();
      errors_o  <= 0;
      pending_o <= 0;
      results_o <= 0;
    end else begin
      bad = 0;
      if (in_valid_i && !in_stall_i) begin
        expected_vertices.push_back(transform_vertex(action_i, in_x_i, in_y_i, in_z_i));
      end
      if (out_valid_i && !out_stall_i) begin
        results_o <= results_o + 1;
        seen_v = '{out_x_i, out_y_i, out_z_i, overflow_i};
        if (expected_vertices.size() == 0) begin
          $error("output word with no vertex pending: x %0d y %0d z %0d overflow %0b",
                 seen_v.x, seen_v.y, seen_v.z, seen_v.overflow);
          bad = 1;
        end else begin
          want_v = expected_vertices.pop_front();
          bad += check_field("out_x", want_v.x, seen_v.x);
          bad += check_field("out_y", want_v.y, seen_v.y);
          bad += check_field("out_z", want_v.z, seen_v.z);
          bad += check_field("overflow", {31'b0, want_v.overflow}, {31'b0, seen_v.overflow});
        end
      end
      errors_o  <= errors_o + bad;
      pending_o <= expected_vertices.size();
      // Writes beyond the last register are dropped by the block.
      if (psel && penable && pwrite && pready &&
          paddr[avt_pkg::ADDR_W-1:3] < avt_pkg::NUM_REGS) begin
        matrix_q[paddr[avt_pkg::ADDR_W-1:3]] <= pwdata;
      end
    end
  end

endmodule

`default_nettype wire

/* tb/affine_vertex_transform_tb.sv */
// Testbench top for the affine vertex transform: clock, reset, APB matrix loads,
// vertex stimulus and the receiver, with the verdict at the end.
// Depends on avt_pkg, affine_vertex_transform and avt_result_check.
`default_nettype none

module affine_vertex_transform_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC     = 16;
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned PHASES   = 7;
  localparam int unsigned PER_SET  = 150;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  localparam logic [avt_pkg::REG_IDX_W-1:0] REG_UNMAPPED_6 = 3'd6;
  localparam logic [avt_pkg::REG_IDX_W-1:0] REG_UNMAPPED_7 = 3'd7;

  localparam logic ACT_POINT = 1'b0;
  localparam logic ACT_DIR   = 1'b1;

  typedef enum int unsigned {COEF_SMALL, COEF_FULL, COEF_EXTREME} coef_mix_e;

  logic                       clk_i   = 1'b0;
  logic                       rst_ni  = 1'b0;
  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [avt_pkg::ADDR_W-1:0] paddr   = '0;
  logic [avt_pkg::DATA_W-1:0] pwdata  = '0;
  logic [avt_pkg::DATA_W-1:0] prdata;
  logic                       pready;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       action   = 1'b0;
  logic signed [31:0]         in_x     = '0;
  logic signed [31:0]         in_y     = '0;
  logic signed [31:0]         in_z     = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [31:0]         out_x;
  logic signed [31:0]         out_y;
  logic signed [31:0]         out_z;
  logic                       overflow;

  int unsigned errors;
  int unsigned pending;
  int unsigned results;
  int unsigned sent     = 0;
  bit          quiet    = 1'b0;
  bit          hold_arm = 1'b0;

  affine_vertex_transform #(
    .FRAC_BITS  (FRAC),
    .COORD_WIDTH(COORD_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .action_i   (action),
    .in_x_i     (in_x),
    .in_y_i     (in_y),
    .in_z_i     (in_z),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_x_o    (out_x),
    .out_y_o    (out_y),
    .out_z_o    (out_z),
    .overflow_o (overflow)
  );

  avt_result_check #(
    .FRAC_BITS  (FRAC),
    .COORD_WIDTH(COORD_W)
  ) u_result_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .action_i   (action),
    .in_x_i     (in_x),
    .in_y_i     (in_y),
    .in_z_i     (in_z),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_x_i    (out_x),
    .out_y_i    (out_y),
    .out_z_i    (out_z),
    .overflow_i (overflow),
    .errors_o   (errors),
    .pending_o  (pending),
    .results_o  (results)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] pick_coef(coef_mix_e mix);
    logic [31:0] r;
    r = $urandom;
    case (mix)
      COEF_SMALL: return {{14{r[17]}}, r[17:0]};
      COEF_EXTREME: begin
        case ($urandom_range(6))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          4: return Q_ONE;
          5: return -Q_ONE;
          default: return r;
        endcase
      end
      default: return r;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return 32'sd0;
      3: return -32'sd1;
      4, 5, 6: return {{12{r[19]}}, r[19:0]};
      default: return r;
    endcase
  endfunction

  // Setup cycle, then access cycles until pready, then psel held low before the
  // next access so that psel is never dropped and raised again at the same edge.
  task automatic write_reg(input logic [avt_pkg::REG_IDX_W-1:0] idx,
                           input logic [avt_pkg::DATA_W-1:0] value);
    bit ready;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= avt_pkg::ADDR_W'({idx, 3'b000});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      ready = pready;
      @(posedge clk_i);
    end while (!ready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_matrix(input coef_mix_e mix);
    logic [avt_pkg::REG_IDX_W-1:0] reg_map [avt_pkg::NUM_REGS];
    reg_map = '{avt_pkg::REG_ROW_X_AB, avt_pkg::REG_ROW_X_C_OFF, avt_pkg::REG_ROW_Y_AB,
                avt_pkg::REG_ROW_Y_C_OFF, avt_pkg::REG_ROW_Z_AB, avt_pkg::REG_ROW_Z_C_OFF};
    for (int i = 0; i < avt_pkg::NUM_REGS; i++) begin
      write_reg(reg_map[i], {pick_coef(mix), pick_coef(mix)});
    end
  endtask

  // Offers one vertex word and returns at the edge that accepts it. Valid stays
  // high into the next word unless a random gap is taken first.
  task automatic send_vertex(input logic act, input logic signed [31:0] x,
                             input logic signed [31:0] y, input logic signed [31:0] z);
    bit taken;
    if (!quiet && $urandom_range(99) < 3) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    action   <= act;
    in_x     <= x;
    in_y     <= y;
    in_z     <= z;
    do begin
      @(negedge clk_i);
      taken = !in_stall;
      @(posedge clk_i);
    end while (!taken);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus one long hold-off counted here once armed.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_arm) begin
        hold_arm  = 1'b0;
        hold_left = 150;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 8);
      end
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity matrix from reset: coordinates pass through unchanged.
    send_vertex(ACT_POINT, 32'sd0, 32'sd0, 32'sd0);
    send_vertex(ACT_POINT, Q_MAX, Q_MIN, -32'sd1);
    send_vertex(ACT_DIR, Q_MIN, Q_MAX, 32'sd1);
    send_vertex(ACT_POINT, Q_ONE, -Q_ONE, 32'sh7FFF_0000);
    send_vertex(ACT_DIR, -32'sh0000_8000, 32'sd1, Q_MIN);
    wait_drained();

    // Rows that saturate high and low, and a z row with a unit translation.
    write_reg(avt_pkg::REG_ROW_X_AB, {Q_MAX, Q_MAX});
    write_reg(avt_pkg::REG_ROW_X_C_OFF, {Q_MAX, Q_MAX});
    write_reg(avt_pkg::REG_ROW_Y_AB, {Q_MIN, Q_MIN});
    write_reg(avt_pkg::REG_ROW_Y_C_OFF, {Q_MIN, Q_MIN});
    write_reg(avt_pkg::REG_ROW_Z_AB, {32'sd0, Q_ONE});
    write_reg(avt_pkg::REG_ROW_Z_C_OFF, {Q_ONE, 32'sd0});
    send_vertex(ACT_POINT, Q_MAX, Q_MAX, Q_MAX);
    send_vertex(ACT_DIR, Q_MAX, Q_MAX, Q_MAX);
    send_vertex(ACT_POINT, Q_MIN, Q_MIN, Q_MIN);
    send_vertex(ACT_DIR, Q_MIN, Q_MIN, Q_MIN);
    send_vertex(ACT_POINT, 32'sd0, 32'sd0, 32'sd0);
    send_vertex(ACT_POINT, 32'sd1, -32'sd1, Q_MIN);
    send_vertex(ACT_DIR, -32'sd1, -32'sd1, -32'sd1);
    wait_drained();

    // Writes past the last register must leave the matrix alone.
    write_reg(REG_UNMAPPED_6, '1);
    write_reg(REG_UNMAPPED_7, '1);
    send_vertex(ACT_POINT, Q_MAX, 32'sd0, 32'sd0);
    send_vertex(ACT_DIR, 32'sd0, 32'sd0, Q_MIN);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      if (phase == PHASES - 1) begin
        write_reg(avt_pkg::REG_ROW_X_AB, avt_pkg::RST_ROW_X_AB);
        write_reg(avt_pkg::REG_ROW_X_C_OFF, avt_pkg::RST_ROW_X_C_OFF);
        write_reg(avt_pkg::REG_ROW_Y_AB, avt_pkg::RST_ROW_Y_AB);
        write_reg(avt_pkg::REG_ROW_Y_C_OFF, avt_pkg::RST_ROW_Y_C_OFF);
        write_reg(avt_pkg::REG_ROW_Z_AB, avt_pkg::RST_ROW_Z_AB);
        write_reg(avt_pkg::REG_ROW_Z_C_OFF, avt_pkg::RST_ROW_Z_C_OFF);
      end else begin
        load_matrix(coef_mix_e'(phase % 3));
      end
      quiet = (phase == 3);
      // The receiver holds off while words keep coming, so the pipe fills.
      if (phase == 4) begin
        hold_arm = 1'b1;
      end
      for (int n = 0; n < PER_SET; n++) begin
        if (phase == 1 && n == PER_SET / 2) begin
          wait_drained();
        end
        send_vertex(1'($urandom_range(1)), pick_coord(), pick_coord(), pick_coord());
      end
    end
    wait_drained();
    quiet = 1'b0;
    repeat (8) @(posedge clk_i);

    $display("Sent %0d vertex words and checked %0d results over %0d matrix settings,",
             sent, results, PHASES + 2);
    $display("covering saturation both ways, points and directions, and unmapped writes.");
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
